>>> src/chcm_pkg.sv
// ----------------------------------------------------------------------------
// chcm_pkg
// Shared types and constants of the CLAHE histogram CDF mapping block.
// ----------------------------------------------------------------------------
`default_nettype none

package chcm_pkg;

   localparam int LEVEL_W    = 16;
   localparam int PIX_W      = 25;
   localparam int COUNT_W    = 25;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 25;

   localparam logic [CSR_IDX_W-1:0] CSR_OUT_MIN       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_MAX       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_PIXELS = 2'd2;

   localparam logic [LEVEL_W-1:0] OUT_MIN_RESET       = 16'd0;
   localparam logic [LEVEL_W-1:0] OUT_MAX_RESET       = 16'hFFFF;
   localparam logic [PIX_W-1:0]   REGION_PIXELS_RESET = 25'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_MAP
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

>>> src/chcm_div_unit.sv
// ----------------------------------------------------------------------------
// chcm_div_unit
// Restoring serial divider: one compare-and-subtract per cycle, one quotient
// bit per step.
// ----------------------------------------------------------------------------
`default_nettype none

module chcm_div_unit #(
   parameter int DW = 41,
   parameter int VW = 25
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic [DW-1:0]           dividend,
   input  wire logic [VW-1:0]           divisor,
   output logic      [DW-1:0]           quotient,
   output chcm_pkg::div_status_type     status
);

   localparam int CntW = $clog2(DW + 1);

   logic [VW-1:0]   rem_ff, rem_in;
   logic [DW-1:0]   quo_ff, quo_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;

   logic [VW:0]     rem_sh;
   logic [VW:0]     diff;
   logic            ge;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[DW-1]};
      diff    = rem_sh - {1'b0, divisor};
      ge      = ~diff[VW];
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = CntW'(DW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[VW-1:0] : rem_sh[VW-1:0];
         quo_in = {quo_ff[DW-2:0], ge};
         cnt_in = cnt_ff - CntW'(1);
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

`default_nettype wire

>>> src/clahe_histogram_cdf_map_top.sv
// ----------------------------------------------------------------------------
// clahe_histogram_cdf_map_top
// CLAHE cumulative mapping: running bin sum scaled by the output span, divided
// by the region size, plus the output minimum, clamped to the output range.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    bin_count, last_bin
//   rsp      out        rsp_valid/stall    mapped_level, region_done
//   csr      in         csr_write_enable   csr_index, csr_write_data
//
// A bin is taken only in the idle state; requests stall through the multiply,
// divide and map states, so a new bin waits until the last one's result is
// loaded into the output register. The serial divider produces one quotient bit
// per cycle over SUM_WIDTH + 16 bits.
// Reset clears the running sum and loads the register defaults.
// The next bin is taken while a finished result waits on rsp_stall; a result
// that finds the output register still full holds until it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module clahe_histogram_cdf_map_top #(
   parameter int SUM_WIDTH  = 25,
   parameter int GRAY_WIDTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic [chcm_pkg::COUNT_W-1:0]           req_bin_count,
   input  wire logic                                   req_last_bin,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic      [GRAY_WIDTH-1:0]                  rsp_mapped_level,
   output logic                                        rsp_region_done,
   input  wire logic                                   csr_write_enable,
   input  wire logic [chcm_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [chcm_pkg::CSR_DATA_W-1:0]        csr_write_data
);

   localparam int LW   = chcm_pkg::LEVEL_W;
   localparam int DW   = SUM_WIDTH + LW;
   localparam int AccW = ((SUM_WIDTH > chcm_pkg::COUNT_W) ?
                          SUM_WIDTH : chcm_pkg::COUNT_W) + 1;

   chcm_pkg::state_type      state_ff, state_in;
   chcm_pkg::div_status_type div_stat;

   logic [LW-1:0]                 out_min_ff;
   logic [LW-1:0]                 out_max_ff;
   logic [chcm_pkg::PIX_W-1:0]    pixels_ff;
   logic [SUM_WIDTH-1:0]          running_ff, running_in;
   logic [SUM_WIDTH-1:0]          sum_ff;
   logic                          last_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [GRAY_WIDTH-1:0]         level_ff;
   logic                          done_ff;

   logic                          req_beat;
   logic                          rsp_load;
   logic [AccW-1:0]               sum_wide;
   logic [SUM_WIDTH-1:0]          sum_sat;
   logic [LW-1:0]                 span;
   logic                          bypass;
   logic [DW-1:0]                 product;
   logic [DW-1:0]                 quotient;
   logic                          over;
   logic [LW:0]                   level_sum;
   logic [LW-1:0]                 level;

   assign req_beat = req_valid && !req_stall;

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         out_min_ff <= chcm_pkg::OUT_MIN_RESET;
         out_max_ff <= chcm_pkg::OUT_MAX_RESET;
         pixels_ff  <= chcm_pkg::REGION_PIXELS_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            chcm_pkg::CSR_OUT_MIN:       out_min_ff <= csr_write_data[LW-1:0];
            chcm_pkg::CSR_OUT_MAX:       out_max_ff <= csr_write_data[LW-1:0];
            chcm_pkg::CSR_REGION_PIXELS: pixels_ff  <= csr_write_data[chcm_pkg::PIX_W-1:0];
            default: ;
         endcase
      end
   end

   // accumulate, saturating
   always_comb begin
      sum_wide = AccW'(running_ff) + AccW'(req_bin_count);
      if (sum_wide > AccW'({SUM_WIDTH{1'b1}})) begin
         sum_sat = '1;
      end else begin
         sum_sat = sum_wide[SUM_WIDTH-1:0];
      end
      running_in = running_ff;
      if (req_beat) begin
         running_in = req_last_bin ? '0 : sum_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= '0;
      end else begin
         running_ff <= running_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         sum_ff  <= sum_sat;
         last_ff <= req_last_bin;
      end
   end

   // scale
   assign span    = out_max_ff - out_min_ff;
   assign bypass  = (out_max_ff < out_min_ff) || (pixels_ff == '0);
   assign product = {{LW{1'b0}}, sum_ff} * {{SUM_WIDTH{1'b0}}, span};

   chcm_div_unit #(
      .DW (DW),
      .VW (chcm_pkg::PIX_W)
   ) u_chcm_div_unit (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == chcm_pkg::ST_MUL),
      .dividend (product),
      .divisor  (pixels_ff),
      .quotient (quotient),
      .status   (div_stat)
   );

   // offset and clamp
   always_comb begin
      over      = (|quotient[DW-1:LW]) || (quotient[LW-1:0] > span);
      level_sum = {1'b0, out_min_ff} + {1'b0, quotient[LW-1:0]};
      level     = (bypass || over) ? out_max_ff : level_sum[LW-1:0];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= chcm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      rsp_load  = 1'b0;
      case (state_ff)
         chcm_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               state_in = chcm_pkg::ST_MUL;
            end
         end
         chcm_pkg::ST_MUL: begin
            state_in = chcm_pkg::ST_DIV;
         end
         chcm_pkg::ST_DIV: begin
            if (div_stat.done && !div_stat.busy) begin
               state_in = chcm_pkg::ST_MAP;
            end
         end
         chcm_pkg::ST_MAP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = chcm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = chcm_pkg::ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         level_ff <= level[GRAY_WIDTH-1:0];
         done_ff  <= last_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mapped_level = level_ff;
   assign rsp_region_done  = done_ff;

endmodule

`default_nettype wire

>>> src/chcm_checker.sv
// ----------------------------------------------------------------------------
// chcm_checker
// Port-level checks of the CLAHE CDF mapping block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module chcm_checker #(
   parameter int GRAY_WIDTH = 16
) (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_valid,
   input wire logic                               req_stall,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_stall,
   input wire logic [GRAY_WIDTH-1:0]              rsp_mapped_level,
   input wire logic                               rsp_region_done
);

   // hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_mapped_level)
                                 && $stable(rsp_region_done))
      else $error("stalled result beat changed");

   // busy right after taking a bin
   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("bin beat taken without going busy");

   // new result only out of a busy cycle
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without work in flight");

   // empty and ready after reset
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("not idle after reset");

endmodule

bind clahe_histogram_cdf_map_top chcm_checker #(
   .GRAY_WIDTH (GRAY_WIDTH)
) u_chcm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_mapped_level (rsp_mapped_level),
   .rsp_region_done  (rsp_region_done)
);

`default_nettype wire
